// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the kinematic integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define KINT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kinematic integrator assertion failed");

// Checks that a signal holds its value in the cycle after a condition.
`define KINT_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("kinematic integrator signal did not hold");

`endif

// File: rtl/kint_pkg.sv
// Shared types and constants of the six-axis kinematic integrator.
package kint_pkg;

    localparam int TOTAL_AXES  = 6;
    localparam int LINEAR_AXES = 3;
    localparam int DATA_W      = 32;
    localparam int TS_W        = 24;
    localparam int EXT_W       = 31;
    localparam int FRAC_SHIFT  = 24;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [DATA_W-1:0] t_q16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME     = 3'd0,
        CFG_HALF_STEP_SQ  = 3'd1,
        CFG_ROOM_X_ORIGIN = 3'd2,
        CFG_ROOM_X_EXTENT = 3'd3,
        CFG_ROOM_Y_ORIGIN = 3'd4,
        CFG_ROOM_Y_EXTENT = 3'd5,
        CFG_ROOM_Z_ORIGIN = 3'd6,
        CFG_ROOM_Z_EXTENT = 3'd7
    } t_cfg_reg;

    localparam logic [TS_W-1:0]  STEP_TIME_RST    = 24'd16777;
    localparam logic [TS_W-1:0]  HALF_STEP_SQ_RST = 24'd8;
    localparam t_q16             ORIGIN_RST       = 32'sd0;
    localparam logic [EXT_W-1:0] EXTENT_RST       = 31'd655360;

    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  hts;
        t_q16             origin;
        logic [EXT_W-1:0] extent;
    } t_axis_cfg;

endpackage

// File: rtl/kint_axis.sv
// One axis of the integrator: value and rate state with the saturating update and room wrap.
module kint_axis import kint_pkg::*; #(
    parameter bit WRAP = 1'b0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_q16      i_accel,
    input  t_axis_cfg i_cfg,
    output t_q16      o_value
);

    localparam int PROD_W = TS_W + DATA_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int FLR_W  = SUM_W - FRAC_SHIFT;

    function automatic t_q16 sat_q16(input logic signed [FLR_W-1:0] x);
        logic signed [FLR_W-1:0] hi_lim;
        logic signed [FLR_W-1:0] lo_lim;
        hi_lim = FLR_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo_lim = -hi_lim - FLR_W'(1);
        if (x > hi_lim) begin
            return t_q16'(hi_lim);
        end else if (x < lo_lim) begin
            return t_q16'(lo_lim);
        end
        return t_q16'(x);
    endfunction

    t_q16 r_value;
    t_q16 r_rate;

    logic signed [TS_W:0]       w_ts;
    logic signed [TS_W:0]       w_hts;
    logic signed [PROD_W-1:0]   w_p_rate;
    logic signed [PROD_W-1:0]   w_p_pos;
    logic signed [PROD_W-1:0]   w_p_vel;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [FLR_W-1:0]    w_floor;
    t_q16                       w_dr;
    logic signed [FLR_W-1:0]    w_rate_sum;
    logic signed [FLR_W-1:0]    w_hi_sum;
    t_q16                       w_val_sat;
    t_q16                       w_hi;
    t_q16                       n_value;
    t_q16                       n_rate;

    assign w_ts     = $signed({1'b0, i_cfg.ts});
    assign w_hts    = $signed({1'b0, i_cfg.hts});
    assign w_p_rate = w_ts * r_rate;
    assign w_p_pos  = w_hts * i_accel;
    assign w_p_vel  = w_ts * i_accel;

    // Value in Q16.40, then an arithmetic shift floors back to Q16.16.
    assign w_sum = (SUM_W'(r_value) <<< FRAC_SHIFT) + SUM_W'(w_p_rate) + SUM_W'(w_p_pos);
    assign w_floor   = w_sum[SUM_W-1:FRAC_SHIFT];
    assign w_val_sat = sat_q16(w_floor);

    // The floored rate increment always fits 32 signed bits since ts stays below one.
    assign w_dr       = $signed(w_p_vel[FRAC_SHIFT+DATA_W-1:FRAC_SHIFT]);
    assign w_rate_sum = FLR_W'(r_rate) + FLR_W'(w_dr);
    assign n_rate     = sat_q16(w_rate_sum);

    assign w_hi_sum = FLR_W'(i_cfg.origin) + $signed(FLR_W'(i_cfg.extent));
    assign w_hi     = sat_q16(w_hi_sum);

    always_comb begin
        n_value = w_val_sat;
        if (WRAP) begin
            if (n_value < i_cfg.origin) begin
                n_value = w_hi;
            end
            if (n_value > w_hi) begin
                n_value = i_cfg.origin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_rate  <= '0;
        end else if (i_adv) begin
            r_value <= n_value;
            r_rate  <= n_rate;
        end
    end

    assign o_value = n_value;

endmodule

// File: rtl/six_axis_kinematic_integrator_wrap.sv
// Six-axis kinematic integrator: one item per clock cycle in steady flow, while the output
// is not stalled. An accepted item lands in the input register; once the result register is
// empty or being drained, every axis does its value and rate update in one combinational pass
// (three 25 x 32 multiplies, a 58-bit sum, saturation and the room wrap) into the result
// register, where it waits until it is taken. Each axis carries its state from item to item
// through its own value and rate registers. Configuration is read when an item is updated, not
// when it is accepted; write only while no item is in flight.
module six_axis_kinematic_integrator_wrap import kint_pkg::*; #(
    parameter int NUM_AXES = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_q16                 i_accel_x,
    input  t_q16                 i_accel_y,
    input  t_q16                 i_accel_z,
    input  t_q16                 i_accel_roll,
    input  t_q16                 i_accel_pitch,
    input  t_q16                 i_accel_yaw,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_q16                 o_pos_x,
    output t_q16                 o_pos_y,
    output t_q16                 o_pos_z,
    output t_q16                 o_angle_roll,
    output t_q16                 o_angle_pitch,
    output t_q16                 o_angle_yaw
);

    logic [TS_W-1:0]  r_step_time;
    logic [TS_W-1:0]  r_half_step_sq;
    t_q16             r_origin [LINEAR_AXES];
    logic [EXT_W-1:0] r_extent [LINEAR_AXES];

    logic r_in_valid;
    t_q16 r_acc [TOTAL_AXES];
    logic r_out_valid;
    t_q16 r_out [TOTAL_AXES];

    t_q16 w_acc_in [TOTAL_AXES];
    t_q16 w_next   [TOTAL_AXES];
    logic w_adv;
    logic w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time    <= STEP_TIME_RST;
            r_half_step_sq <= HALF_STEP_SQ_RST;
            for (int i = 0; i < LINEAR_AXES; i++) begin
                r_origin[i] <= ORIGIN_RST;
                r_extent[i] <= EXTENT_RST;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STEP_TIME:     r_step_time    <= i_cfg_data[TS_W-1:0];
                CFG_HALF_STEP_SQ:  r_half_step_sq <= i_cfg_data[TS_W-1:0];
                CFG_ROOM_X_ORIGIN: r_origin[0]    <= $signed(i_cfg_data);
                CFG_ROOM_X_EXTENT: r_extent[0]    <= i_cfg_data[EXT_W-1:0];
                CFG_ROOM_Y_ORIGIN: r_origin[1]    <= $signed(i_cfg_data);
                CFG_ROOM_Y_EXTENT: r_extent[1]    <= i_cfg_data[EXT_W-1:0];
                CFG_ROOM_Z_ORIGIN: r_origin[2]    <= $signed(i_cfg_data);
                CFG_ROOM_Z_EXTENT: r_extent[2]    <= i_cfg_data[EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_acc_in[0] = i_accel_x;
    assign w_acc_in[1] = i_accel_y;
    assign w_acc_in[2] = i_accel_z;
    assign w_acc_in[3] = i_accel_roll;
    assign w_acc_in[4] = i_accel_pitch;
    assign w_acc_in[5] = i_accel_yaw;

    // The update stage moves whenever it holds an item and the result register is empty or being drained.
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            for (int i = 0; i < TOTAL_AXES; i++) begin
                r_acc[i] <= w_acc_in[i];
            end
        end
    end

    for (genvar a = 0; a < TOTAL_AXES; a++) begin : g_axis
        if (a < NUM_AXES) begin : g_on
            t_axis_cfg w_cfg;
            if (a < LINEAR_AXES) begin : g_lin
                assign w_cfg = '{ts: r_step_time, hts: r_half_step_sq,
                                 origin: r_origin[a], extent: r_extent[a]};
            end else begin : g_ang
                assign w_cfg = '{ts: r_step_time, hts: r_half_step_sq,
                                 origin: '0, extent: '0};
            end
            kint_axis #(
                .WRAP(a < LINEAR_AXES)
            ) u_axis (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_accel (r_acc[a]),
                .i_cfg   (w_cfg),
                .o_value (w_next[a])
            );
        end else begin : g_off
            assign w_next[a] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < TOTAL_AXES; i++) begin
                r_out[i] <= w_next[i];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out[0];
    assign o_pos_y       = r_out[1];
    assign o_pos_z       = r_out[2];
    assign o_angle_roll  = r_out[3];
    assign o_angle_pitch = r_out[4];
    assign o_angle_yaw   = r_out[5];

endmodule

// File: rtl/kint_checker.sv
// Port-level checks of the kinematic integrator and their binding to the top level.
`include "assert_macros.svh"

module kint_checker import kint_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_q16 o_pos_x,
    input t_q16 o_angle_yaw
);

    `KINT_ASSERT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `KINT_ASSERT_HOLD(a_out_pos_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_pos_x)
    `KINT_ASSERT(a_stall_only_on_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    `KINT_ASSERT(a_item_reaches_out, i_clk, i_rst_n, i_in_valid && !o_in_stall ##1 !i_out_stall |=> o_out_valid)
    `KINT_ASSERT_HOLD(a_out_yaw_holds, i_clk, i_rst_n, o_out_valid && i_out_stall && !o_in_stall, o_angle_yaw)

endmodule

bind six_axis_kinematic_integrator_wrap kint_checker u_kint_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_pos_x     (o_pos_x),
    .o_angle_yaw (o_angle_yaw)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the six-axis kinematic integrator with room wrap.
module tb_top;
    import kint_pkg::*;

    localparam int AXES_USED   = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 100;

    typedef logic [TOTAL_AXES-1:0][DATA_W-1:0] t_pose;

    typedef struct packed {
        logic [TS_W-1:0]                     ts;
        logic [TS_W-1:0]                     hts;
        logic [LINEAR_AXES-1:0][DATA_W-1:0]  origin;
        logic [LINEAR_AXES-1:0][EXT_W-1:0]   extent;
    } t_room_setting;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    t_cfg_reg          cfg_index = CFG_STEP_TIME;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_pose             accel_drv = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_q16              pos_x, pos_y, pos_z, angle_roll, angle_pitch, angle_yaw;

    // Shadow of the integrator state and its register settings.
    longint motion_value [TOTAL_AXES];
    longint motion_rate  [TOTAL_AXES];
    longint ts_q24;
    longint hts_q24;
    longint room_lo   [LINEAR_AXES];
    longint room_span [LINEAR_AXES];

    t_pose  pending_poses [$];
    int     error_count      = 0;
    int     quiet_cycles     = 0;
    bit     sender_idle_on   = 1'b1;
    bit     receiver_idle_on = 1'b1;
    bit     hold_request     = 1'b0;
    string  pose_field [TOTAL_AXES] =
        '{"pos_x", "pos_y", "pos_z", "angle_roll", "angle_pitch", "angle_yaw"};

    six_axis_kinematic_integrator_wrap #(
        .NUM_AXES(AXES_USED)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_accel_x    (accel_drv[0]),
        .i_accel_y    (accel_drv[1]),
        .i_accel_z    (accel_drv[2]),
        .i_accel_roll (accel_drv[3]),
        .i_accel_pitch(accel_drv[4]),
        .i_accel_yaw  (accel_drv[5]),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pos_x      (pos_x),
        .o_pos_y      (pos_y),
        .o_pos_z      (pos_z),
        .o_angle_roll (angle_roll),
        .o_angle_pitch(angle_pitch),
        .o_angle_yaw  (angle_yaw)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Advances every axis by one sample period and returns the six new values.
    function automatic t_pose advance_motion(input t_pose accel);
        t_pose  pose;
        longint acc, v, r, nv, lo, hi;
        pose = '0;
        for (int i = 0; i < AXES_USED; i++) begin
            acc = $signed(accel[i]);
            v   = motion_value[i];
            r   = motion_rate[i];
            // The arithmetic shift of a signed value rounds toward minus infinity.
            nv  = clamp32(((v <<< FRAC_SHIFT) + ts_q24 * r + hts_q24 * acc) >>> FRAC_SHIFT);
            r   = clamp32(r + ((ts_q24 * acc) >>> FRAC_SHIFT));
            if (i < LINEAR_AXES) begin
                lo = room_lo[i];
                hi = clamp32(lo + room_span[i]);
                if (nv < lo) nv = hi;
                if (nv > hi) nv = lo;
            end
            motion_value[i] = nv;
            motion_rate[i]  = r;
            pose[i]         = nv[DATA_W-1:0];
        end
        return pose;
    endfunction

    function automatic t_q16 random_accel();
        case ($urandom_range(0, 15))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return '0;
            default: return $signed($urandom()) >>> $urandom_range(4, 24);
        endcase
    endfunction

    function automatic t_pose random_pose();
        t_pose pose;
        for (int i = 0; i < TOTAL_AXES; i++) begin
            pose[i] = random_accel();
        end
        return pose;
    endfunction

    function automatic t_room_setting random_setting();
        t_room_setting s;
        longint        step;
        case ($urandom_range(0, 7))
            0: s.ts = '1;
            1: s.ts = '0;
            default: s.ts = TS_W'($urandom() >> $urandom_range(8, 20));
        endcase
        step = s.ts;
        // Mostly a consistent Ts^2/2, sometimes an arbitrary value.
        if ($urandom_range(0, 4) == 0) begin
            s.hts = TS_W'($urandom());
        end else begin
            s.hts = TS_W'((step * step) >> 25);
        end
        for (int a = 0; a < LINEAR_AXES; a++) begin
            case ($urandom_range(0, 5))
                0: s.origin[a] = 32'h8000_0000;
                1: s.origin[a] = 32'h7FFF_FFFF;
                2: s.origin[a] = $urandom();
                default: s.origin[a] = $signed($urandom()) >>> $urandom_range(6, 14);
            endcase
            case ($urandom_range(0, 5))
                0: s.extent[a] = '0;
                1: s.extent[a] = '1;
                2: s.extent[a] = EXT_W'($urandom());
                default: s.extent[a] = EXT_W'($urandom() >> $urandom_range(5, 12));
            endcase
        end
        return s;
    endfunction

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic put_reg(input t_cfg_reg idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_STEP_TIME:     ts_q24       = data[TS_W-1:0];
            CFG_HALF_STEP_SQ:  hts_q24      = data[TS_W-1:0];
            CFG_ROOM_X_ORIGIN: room_lo[0]   = $signed(data);
            CFG_ROOM_X_EXTENT: room_span[0] = data[EXT_W-1:0];
            CFG_ROOM_Y_ORIGIN: room_lo[1]   = $signed(data);
            CFG_ROOM_Y_EXTENT: room_span[1] = data[EXT_W-1:0];
            CFG_ROOM_Z_ORIGIN: room_lo[2]   = $signed(data);
            CFG_ROOM_Z_EXTENT: room_span[2] = data[EXT_W-1:0];
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrower registers carry random junk.
    task automatic load_setting(input t_room_setting s);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        put_reg(CFG_STEP_TIME,     {junk[7:0], s.ts});
        put_reg(CFG_HALF_STEP_SQ,  {junk[15:8], s.hts});
        put_reg(CFG_ROOM_X_ORIGIN, s.origin[0]);
        put_reg(CFG_ROOM_X_EXTENT, {junk[16], s.extent[0]});
        put_reg(CFG_ROOM_Y_ORIGIN, s.origin[1]);
        put_reg(CFG_ROOM_Y_EXTENT, {junk[17], s.extent[1]});
        put_reg(CFG_ROOM_Z_ORIGIN, s.origin[2]);
        put_reg(CFG_ROOM_Z_EXTENT, {junk[18], s.extent[2]});
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input t_pose accel);
        in_valid  <= 1'b1;
        accel_drv <= accel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (sender_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_corner_values();
        send_sample('0);
        send_sample({TOTAL_AXES{32'h7FFF_FFFF}});
        send_sample({TOTAL_AXES{32'h8000_0000}});
        send_sample({TOTAL_AXES{32'hFFFF_FFFF}});
        send_sample({TOTAL_AXES{32'h0000_0001}});
        send_sample({{3{32'hAAAA_AAAA}}, {3{32'h5555_5555}}});
        wait_for_results();
    endtask

    // X crosses both edges of a small room, y has an upper edge past the
    // signed maximum, and z is a room of zero size.
    task automatic test_room_wrap();
        t_room_setting s;
        s.ts        = 24'h80_0000;
        s.hts       = 24'h20_0000;
        s.origin[0] = -32'sd65536;
        s.extent[0] = 31'd131072;
        s.origin[1] = 32'h7000_0000;
        s.extent[1] = 31'h7FFF_FFFF;
        s.origin[2] = 32'h0001_0000;
        s.extent[2] = '0;
        load_setting(s);
        send_sample({TOTAL_AXES{32'h0010_0000}});
        send_sample({TOTAL_AXES{32'hFFE0_0000}});
        send_sample('0);
        send_sample('0);
        send_sample({TOTAL_AXES{32'h0000_8000}});
        send_sample({TOTAL_AXES{32'hFFFF_8000}});
        wait_for_results();
    endtask

    // Largest step and largest accelerations drive values and rates into saturation.
    task automatic test_saturation();
        t_room_setting s;
        s.ts        = '1;
        s.hts       = '1;
        s.origin[0] = 32'h8000_0000;
        s.extent[0] = '1;
        s.origin[1] = '0;
        s.extent[1] = '1;
        s.origin[2] = 32'h7FFF_FFFF;
        s.extent[2] = '1;
        load_setting(s);
        repeat (4) send_sample({TOTAL_AXES{32'h7FFF_FFFF}});
        repeat (5) send_sample({TOTAL_AXES{32'h8000_0000}});
        send_sample('0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            load_setting(random_setting());
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            repeat (200) send_sample(random_pose());
            wait_for_results();
        end
    endtask

    // The receiver holds off long enough for the block to back up to its input.
    task automatic test_backpressure();
        sender_idle_on = 1'b0;
        hold_request   = 1'b1;
        repeat (40) send_sample(random_pose());
        wait_for_results();
    endtask

    task automatic test_steady_flow();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        load_setting(random_setting());
        repeat (80) send_sample(random_pose());
        wait_for_results();
    endtask

    // Results are checked before the same edge's item enters the prediction.
    always @(posedge clk) begin : pose_monitor
        t_pose seen;
        t_pose want;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (rst_n && out_valid && !out_stall) begin
            seen = {angle_yaw, angle_pitch, angle_roll, pos_z, pos_y, pos_x};
            if (pending_poses.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: result with no item pending, expected none, actual %h",
                             $time, seen);
                end
            end else begin
                want = pending_poses.pop_front();
                for (int i = 0; i < TOTAL_AXES; i++) begin
                    if (seen[i] !== want[i]) begin
                        error_count = error_count + 1;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%0t: %s expected %h actual %h",
                                     $time, pose_field[i], want[i], seen[i]);
                        end
                    end
                end
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            pending_poses.push_back(advance_motion(accel_drv));
        end
    end

    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        for (int i = 0; i < TOTAL_AXES; i++) begin
            motion_value[i] = 0;
            motion_rate[i]  = 0;
        end
        for (int a = 0; a < LINEAR_AXES; a++) begin
            room_lo[a]   = $signed(ORIGIN_RST);
            room_span[a] = EXTENT_RST;
        end
        ts_q24  = STEP_TIME_RST;
        hts_q24 = HALF_STEP_SQ_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_values();
        test_room_wrap();
        test_saturation();
        test_random_traffic();
        test_backpressure();
        test_steady_flow();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
